>>> sv/half_duplex_echo_collision_link_macros.svh
// Assertion macros for the half-duplex link controller.
// Included by the top level; expects clk and rst_n in scope.
`ifndef HALF_DUPLEX_ECHO_COLLISION_LINK_MACROS_SVH
`define HALF_DUPLEX_ECHO_COLLISION_LINK_MACROS_SVH
`ifndef NO_ASSERTIONS
// expr must never be true outside reset
`define HDECL_ASSERT_NEVER(label, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("assertion failed");
// ante at an edge implies cons at the same edge
`define HDECL_ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`else
`define HDECL_ASSERT_NEVER(label, expr)
`define HDECL_ASSERT_IMPLIES(label, ante, cons)
`endif
`endif

>>> sv/hdecl_pkg.sv
`timescale 1ns / 1ps
// Types and constants of the half-duplex link controller.
// No dependencies.
package hdecl_pkg;

    localparam int FRAME_DEPTH = 512;
    localparam int IDX_W       = $clog2(FRAME_DEPTH + 1);
    localparam int ADDR_W      = $clog2(FRAME_DEPTH);

    // output queue
    localparam int OQ_DEPTH = 8;
    localparam int OQ_PTR_W = $clog2(OQ_DEPTH);
    localparam int OQ_CNT_W = $clog2(OQ_DEPTH + 1);

    localparam logic [7:0] RAND_MASK = 8'h0f;

    typedef enum logic [2:0] {
        CMD_TICK    = 3'd0,
        CMD_RX      = 3'd1,
        CMD_RX_ERR  = 3'd2,
        CMD_APPEND  = 3'd3,
        CMD_REQUEST = 3'd4,
        CMD_TX_RDY  = 3'd5,
        CMD_ABORT   = 3'd6
    } cmd_t;

    typedef enum logic [2:0] {
        KIND_FWD     = 3'd0,
        KIND_FRAMING = 3'd1,
        KIND_TX_BYTE = 3'd2,
        KIND_DONE    = 3'd3,
        KIND_START   = 3'd4
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_COLLISION = 2'd1,
        ST_ABORTED   = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        MODE_IDLE   = 2'd0,
        MODE_ACTIVE = 2'd1
    } link_mode_t;

    typedef enum logic [2:0] {
        REG_ECHO_CHECK     = 3'd0,
        REG_RX_GAP_TIMEOUT = 3'd1,
        REG_QUIET_GAP      = 3'd2,
        REG_COLLISION_WAIT = 3'd3,
        REG_SUCCESS_WAIT   = 3'd4
    } cfg_reg_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] data;
        status_t    status;
        logic       last;
    } result_t;

endpackage

>>> sv/half_duplex_echo_collision_link.sv
`timescale 1ns / 1ps
// Half-duplex serial link controller with echo-based collision detection.
// Depends on hdecl_pkg and half_duplex_echo_collision_link_macros.svh.
//
// Channel   Dir  Signals                              Contents
// s_*       in   s_tvalid/s_tready/s_tdata/s_tuser    event: cmd, byte_in
// m_*       out  m_tvalid/m_tready/m_tdata/m_tuser    result: kind, byte_out, status, last
// cfg_*     in   cfg_we/cfg_index/cfg_data            register writes, no handshake
//
// One event per cycle while s_tready is high: the store is read at the accepting edge, the next cycle
// executes and queues up to two results, which show on m_* once registered in the output queue.
// Reset needs no clearing pass: the store is only read where it was written.
// s_tready drops while the 8-entry output queue lacks room for two results per event
// in flight, the new one included; only m_tready backpressure causes that.
`include "half_duplex_echo_collision_link_macros.svh"

module half_duplex_echo_collision_link
(
    input  logic        clk,
    input  logic        rst_n,
    // config port
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,
    // event input
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] byte_in
    input  logic [2:0]  s_tuser,   // [2:0] cmd
    // result output
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] byte_out, [9:8] status, [15:10] zero
    output logic [2:0]  m_tuser,   // [2:0] kind
    output logic        m_tlast
);

    localparam int IW = hdecl_pkg::IDX_W;
    localparam int AW = hdecl_pkg::ADDR_W;
    localparam int PW = hdecl_pkg::OQ_PTR_W;
    localparam int CW = hdecl_pkg::OQ_CNT_W;
    localparam logic [IW-1:0] DEPTH_IDX  = IW'(hdecl_pkg::FRAME_DEPTH);
    localparam logic [CW-1:0] LIM_BUSY   = CW'(hdecl_pkg::OQ_DEPTH - 4);
    localparam logic [CW-1:0] LIM_IDLE   = CW'(hdecl_pkg::OQ_DEPTH - 2);
    localparam logic [CW-1:0] OQ_FULL    = CW'(hdecl_pkg::OQ_DEPTH);

    // configuration registers
    logic        echo_check_reg;
    logic [15:0] rx_gap_timeout_reg;
    logic [7:0]  quiet_gap_reg;
    logic [7:0]  collision_wait_reg;
    logic [7:0]  success_wait_reg;

    // link state
    hdecl_pkg::link_mode_t mode_reg, mode_next;
    logic          pending_reg, pending_next;
    logic [IW-1:0] len_reg, len_next;
    logic [IW-1:0] send_reg, send_next;
    logic [IW-1:0] verify_reg, verify_next;
    logic [15:0]   time_reg, time_next;
    logic [15:0]   last_rx_reg, last_rx_next;
    logic [15:0]   backoff_reg, backoff_next;
    logic [7:0]    last_byte_reg, last_byte_next;

    // execute stage
    logic          e_valid_reg;
    logic [2:0]    e_cmd_reg;
    logic [7:0]    e_byte_reg;

    // frame store
    logic [7:0]    frame_mem [hdecl_pkg::FRAME_DEPTH];
    logic [7:0]    rd_data_reg;
    logic [AW-1:0] rd_addr;
    logic          mem_we;

    // output queue
    hdecl_pkg::result_t oq_mem [hdecl_pkg::OQ_DEPTH];
    logic [PW-1:0] wp_reg, rp_reg;
    logic [CW-1:0] cnt_reg;
    hdecl_pkg::result_t slot0, slot1;
    logic          v0, v1;
    logic          s_xfer, m_xfer;

    logic [15:0]   gap;
    logic          fin;
    hdecl_pkg::status_t fin_status;
    logic          start_chk;
    logic          echo_mode;
    logic [7:0]    rand_sum;

    assign s_xfer = s_tvalid & s_tready;
    assign m_xfer = m_tvalid & m_tready;
    assign s_tready = e_valid_reg ? (cnt_reg <= LIM_BUSY) : (cnt_reg <= LIM_IDLE);

    // config writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            echo_check_reg     <= 1'b1;
            rx_gap_timeout_reg <= 16'd15;
            quiet_gap_reg      <= 8'd5;
            collision_wait_reg <= 8'd20;
            success_wait_reg   <= 8'd10;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                hdecl_pkg::REG_ECHO_CHECK:     echo_check_reg     <= cfg_data[0];
                hdecl_pkg::REG_RX_GAP_TIMEOUT: rx_gap_timeout_reg <= cfg_data;
                hdecl_pkg::REG_QUIET_GAP:      quiet_gap_reg      <= cfg_data[7:0];
                hdecl_pkg::REG_COLLISION_WAIT: collision_wait_reg <= cfg_data[7:0];
                hdecl_pkg::REG_SUCCESS_WAIT:   success_wait_reg   <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // execute: next state and results of the event in the execute stage
    always_comb
    begin
        mode_next      = mode_reg;
        pending_next   = pending_reg;
        len_next       = len_reg;
        send_next      = send_reg;
        verify_next    = verify_reg;
        time_next      = time_reg;
        last_rx_next   = last_rx_reg;
        backoff_next   = backoff_reg;
        last_byte_next = last_byte_reg;
        mem_we         = 1'b0;
        fin            = 1'b0;
        fin_status     = hdecl_pkg::ST_OK;
        start_chk      = 1'b0;
        v0             = 1'b0;
        v1             = 1'b0;
        slot0          = '{kind: hdecl_pkg::KIND_FWD, data: 8'd0,
                           status: hdecl_pkg::ST_OK, last: 1'b0};
        slot1          = slot0;
        gap            = time_reg - last_rx_reg;
        echo_mode      = (mode_reg == hdecl_pkg::MODE_ACTIVE) && echo_check_reg;
        rand_sum       = (len_reg[7:0] + last_byte_reg + time_reg[7:0]) & hdecl_pkg::RAND_MASK;

        if (e_valid_reg)
        begin
            case (e_cmd_reg)
                hdecl_pkg::CMD_TICK:
                begin
                    time_next = time_reg + 16'd1;
                    if (backoff_reg != 16'd0)
                        backoff_next = backoff_reg - 16'd1;
                    start_chk = 1'b1;
                end
                hdecl_pkg::CMD_RX:
                begin
                    if (!echo_mode)
                    begin
                        last_rx_next = time_reg;
                        if (gap >= rx_gap_timeout_reg)
                        begin
                            v0 = 1'b1;
                            slot0.kind = hdecl_pkg::KIND_FRAMING;
                            v1 = 1'b1;
                            slot1.kind = hdecl_pkg::KIND_FWD;
                            slot1.data = e_byte_reg;
                        end
                        else
                        begin
                            v0 = 1'b1;
                            slot0.kind = hdecl_pkg::KIND_FWD;
                            slot0.data = e_byte_reg;
                        end
                    end
                    else if (verify_reg >= len_reg || rd_data_reg != e_byte_reg)
                    begin
                        fin = 1'b1;
                        fin_status = hdecl_pkg::ST_COLLISION;
                    end
                    else
                    begin
                        verify_next = verify_reg + IW'(1);
                        if (verify_next >= len_reg)
                            fin = 1'b1;
                    end
                end
                hdecl_pkg::CMD_RX_ERR:
                begin
                    if (!echo_mode)
                    begin
                        last_rx_next = time_reg;
                        v0 = 1'b1;
                        slot0.kind = hdecl_pkg::KIND_FRAMING;
                    end
                    else
                    begin
                        fin = 1'b1;
                        fin_status = hdecl_pkg::ST_COLLISION;
                    end
                end
                hdecl_pkg::CMD_APPEND:
                begin
                    if (mode_reg == hdecl_pkg::MODE_IDLE && !pending_reg && len_reg < DEPTH_IDX)
                    begin
                        mem_we         = 1'b1;
                        len_next       = len_reg + IW'(1);
                        last_byte_next = e_byte_reg;
                    end
                end
                hdecl_pkg::CMD_REQUEST:
                begin
                    if (mode_reg == hdecl_pkg::MODE_IDLE && !pending_reg && len_reg != '0)
                    begin
                        pending_next = 1'b1;
                        start_chk    = 1'b1;
                    end
                end
                hdecl_pkg::CMD_TX_RDY:
                begin
                    if (mode_reg == hdecl_pkg::MODE_ACTIVE && send_reg < len_reg)
                    begin
                        v0 = 1'b1;
                        slot0.kind = hdecl_pkg::KIND_TX_BYTE;
                        slot0.data = rd_data_reg;
                        send_next = send_reg + IW'(1);
                        // without echo checking the frame ends with its last byte
                        if (!echo_check_reg && send_next >= len_reg)
                            fin = 1'b1;
                    end
                end
                hdecl_pkg::CMD_ABORT:
                begin
                    if (mode_reg == hdecl_pkg::MODE_ACTIVE || pending_reg)
                    begin
                        fin = 1'b1;
                        fin_status = hdecl_pkg::ST_ABORTED;
                    end
                    else
                        len_next = '0;
                end
                default: ;
            endcase
        end

        // start once backoff expired and the line has been quiet
        if (start_chk && pending_next && mode_reg == hdecl_pkg::MODE_IDLE &&
            backoff_next == 16'd0 && (time_next - last_rx_reg) >= {8'd0, quiet_gap_reg})
        begin
            pending_next = 1'b0;
            mode_next    = hdecl_pkg::MODE_ACTIVE;
            send_next    = '0;
            verify_next  = '0;
            v0           = 1'b1;
            slot0.kind   = hdecl_pkg::KIND_START;
        end

        if (fin)
        begin
            mode_next    = hdecl_pkg::MODE_IDLE;
            pending_next = 1'b0;
            case (fin_status)
                hdecl_pkg::ST_OK:
                begin
                    backoff_next = {8'd0, success_wait_reg};
                    len_next     = '0;
                end
                hdecl_pkg::ST_COLLISION:
                    backoff_next = {8'd0, collision_wait_reg} + {8'd0, rand_sum};
                default: ;
            endcase
            if (v0)
            begin
                v1 = 1'b1;
                slot1.kind   = hdecl_pkg::KIND_DONE;
                slot1.status = fin_status;
            end
            else
            begin
                v0 = 1'b1;
                slot0.kind   = hdecl_pkg::KIND_DONE;
                slot0.status = fin_status;
            end
        end

        if (v1)
            slot1.last = 1'b1;
        else
            slot0.last = 1'b1;
    end

    // read address follows the state as the executing event leaves it
    assign rd_addr = (s_tuser == hdecl_pkg::CMD_RX) ? verify_next[AW-1:0] : send_next[AW-1:0];

    always_ff @(posedge clk)
    begin
        if (mem_we)
            frame_mem[len_reg[AW-1:0]] <= e_byte_reg;
        if (s_xfer)
            rd_data_reg <= frame_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= hdecl_pkg::MODE_IDLE;
            pending_reg   <= 1'b0;
            len_reg       <= '0;
            send_reg      <= '0;
            verify_reg    <= '0;
            time_reg      <= '0;
            last_rx_reg   <= '0;
            backoff_reg   <= '0;
            last_byte_reg <= '0;
            e_valid_reg   <= 1'b0;
        end
        else
        begin
            mode_reg      <= mode_next;
            pending_reg   <= pending_next;
            len_reg       <= len_next;
            send_reg      <= send_next;
            verify_reg    <= verify_next;
            time_reg      <= time_next;
            last_rx_reg   <= last_rx_next;
            backoff_reg   <= backoff_next;
            last_byte_reg <= last_byte_next;
            e_valid_reg   <= s_xfer;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_xfer)
        begin
            e_cmd_reg  <= s_tuser;
            e_byte_reg <= s_tdata;
        end
    end

    // output queue
    always_ff @(posedge clk)
    begin
        if (v0)
            oq_mem[wp_reg] <= slot0;
        if (v1)
            oq_mem[wp_reg + PW'(1)] <= slot1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wp_reg  <= wp_reg + PW'(v0) + PW'(v1);
            if (m_xfer)
                rp_reg <= rp_reg + PW'(1);
            cnt_reg <= cnt_reg + CW'(v0) + CW'(v1) - CW'(m_xfer);
        end
    end

    assign m_tvalid = (cnt_reg != '0);
    assign m_tuser  = oq_mem[rp_reg].kind;
    assign m_tdata  = {6'd0, oq_mem[rp_reg].status, oq_mem[rp_reg].data};
    assign m_tlast  = oq_mem[rp_reg].last;

    `HDECL_ASSERT_NEVER(a_oq_overflow, cnt_reg > OQ_FULL)
    `HDECL_ASSERT_NEVER(a_pending_while_active, pending_reg && mode_reg == hdecl_pkg::MODE_ACTIVE)
    `HDECL_ASSERT_IMPLIES(a_active_has_frame, mode_reg == hdecl_pkg::MODE_ACTIVE, len_reg != '0)
    `HDECL_ASSERT_IMPLIES(a_send_in_frame, mode_reg != hdecl_pkg::MODE_IDLE, send_reg <= len_reg)
    `HDECL_ASSERT_IMPLIES(a_verify_bound, mode_reg != hdecl_pkg::MODE_IDLE, verify_reg <= len_reg)

endmodule

>>> tb/half_duplex_echo_collision_link_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the half-duplex echo collision link controller.
// Depends on hdecl_pkg and half_duplex_echo_collision_link; predicts every result in a
// small scoreboard class while plain tasks drive events and register writes.
module half_duplex_echo_collision_link_tb;

    localparam int          ITEM_TARGET   = 1650;
    localparam int          SEGMENTS      = 6;
    localparam int          SETTLE_CYCLES = 8;
    localparam logic [2:0]  CMD_UNUSED    = 3'd7;
    localparam int          IDX_W         = hdecl_pkg::IDX_W;
    localparam int          FRAME_DEPTH   = hdecl_pkg::FRAME_DEPTH;

    class link_echo_board_t;
        // registers
        logic             echo_check;
        logic [15:0]      rx_gap_timeout;
        logic [7:0]       quiet_gap;
        logic [7:0]       collision_wait;
        logic [7:0]       success_wait;
        // link state
        hdecl_pkg::link_mode_t mode;
        logic             send_pending;
        logic [7:0]       frame_bytes [FRAME_DEPTH];
        logic [IDX_W-1:0] frame_length;
        logic [IDX_W-1:0] send_index;
        logic [IDX_W-1:0] verify_index;
        logic [15:0]      time_now;
        logic [15:0]      last_rx_time;
        logic [15:0]      backoff_left;
        hdecl_pkg::result_t staged[$];
        hdecl_pkg::result_t expected_results[$];
        int unsigned      error_count;

        function new();
            echo_check     = 1'b1;
            rx_gap_timeout = 16'd15;
            quiet_gap      = 8'd5;
            collision_wait = 8'd20;
            success_wait   = 8'd10;
            mode           = hdecl_pkg::MODE_IDLE;
            send_pending   = 1'b0;
            frame_length   = '0;
            send_index     = '0;
            verify_index   = '0;
            time_now       = '0;
            last_rx_time   = '0;
            backoff_left   = '0;
            error_count    = 0;
        endfunction

        function void set_register(hdecl_pkg::cfg_reg_t idx, logic [15:0] value);
            case (idx)
                hdecl_pkg::REG_ECHO_CHECK:     echo_check     = value[0];
                hdecl_pkg::REG_RX_GAP_TIMEOUT: rx_gap_timeout = value;
                hdecl_pkg::REG_QUIET_GAP:      quiet_gap      = value[7:0];
                hdecl_pkg::REG_COLLISION_WAIT: collision_wait = value[7:0];
                hdecl_pkg::REG_SUCCESS_WAIT:   success_wait   = value[7:0];
                default: ;
            endcase
        endfunction

        function void emit(hdecl_pkg::kind_t kind, logic [7:0] data,
                           hdecl_pkg::status_t status);
            hdecl_pkg::result_t r;
            r.kind   = kind;
            r.data   = data;
            r.status = status;
            r.last   = 1'b0;
            staged.push_back(r);
        endfunction

        function void end_send(hdecl_pkg::status_t status);
            logic [7:0] lastb;
            logic [7:0] mix;
            mode         = hdecl_pkg::MODE_IDLE;
            send_pending = 1'b0;
            if (status == hdecl_pkg::ST_OK)
            begin
                backoff_left = 16'(success_wait);
                frame_length = '0;
            end
            else if (status == hdecl_pkg::ST_COLLISION)
            begin
                lastb = (frame_length != 0) ? frame_bytes[frame_length - 1] : 8'h00;
                // pseudo-random part: low nibble of length + last byte + time, mod 256
                mix = frame_length[7:0] + lastb + time_now[7:0];
                backoff_left = 16'(collision_wait) + 16'(mix & hdecl_pkg::RAND_MASK);
            end
            emit(hdecl_pkg::KIND_DONE, 8'h00, status);
        endfunction

        function void try_launch();
            logic [15:0] quiet;
            quiet = time_now - last_rx_time;
            if (!send_pending || mode != hdecl_pkg::MODE_IDLE || backoff_left != 0)
                return;
            if (quiet < 16'(quiet_gap))
                return;
            send_pending = 1'b0;
            mode         = hdecl_pkg::MODE_ACTIVE;
            send_index   = '0;
            verify_index = '0;
            emit(hdecl_pkg::KIND_START, 8'h00, hdecl_pkg::ST_OK);
        endfunction

        function void apply_event(logic [2:0] cmd, logic [7:0] b);
            logic [15:0] rx_gap;
            staged.delete();
            rx_gap = time_now - last_rx_time;
            case (cmd)
                hdecl_pkg::CMD_TICK:
                begin
                    time_now = time_now + 16'd1;
                    if (backoff_left != 0)
                        backoff_left = backoff_left - 16'd1;
                    try_launch();
                end
                hdecl_pkg::CMD_RX:
                begin
                    if (!(mode == hdecl_pkg::MODE_ACTIVE && echo_check))
                    begin
                        if (rx_gap >= rx_gap_timeout)
                            emit(hdecl_pkg::KIND_FRAMING, 8'h00, hdecl_pkg::ST_OK);
                        last_rx_time = time_now;
                        emit(hdecl_pkg::KIND_FWD, b, hdecl_pkg::ST_OK);
                    end
                    else if (verify_index >= frame_length || frame_bytes[verify_index] != b)
                    begin
                        end_send(hdecl_pkg::ST_COLLISION);
                    end
                    else
                    begin
                        verify_index = verify_index + 1'b1;
                        if (verify_index >= frame_length)
                            end_send(hdecl_pkg::ST_OK);
                    end
                end
                hdecl_pkg::CMD_RX_ERR:
                begin
                    if (!(mode == hdecl_pkg::MODE_ACTIVE && echo_check))
                    begin
                        last_rx_time = time_now;
                        emit(hdecl_pkg::KIND_FRAMING, 8'h00, hdecl_pkg::ST_OK);
                    end
                    else
                    begin
                        end_send(hdecl_pkg::ST_COLLISION);
                    end
                end
                hdecl_pkg::CMD_APPEND:
                begin
                    if (mode == hdecl_pkg::MODE_IDLE && !send_pending &&
                        frame_length < FRAME_DEPTH)
                    begin
                        frame_bytes[frame_length] = b;
                        frame_length = frame_length + 1'b1;
                    end
                end
                hdecl_pkg::CMD_REQUEST:
                begin
                    if (mode == hdecl_pkg::MODE_IDLE && !send_pending && frame_length != 0)
                    begin
                        send_pending = 1'b1;
                        try_launch();
                    end
                end
                hdecl_pkg::CMD_TX_RDY:
                begin
                    if (mode == hdecl_pkg::MODE_ACTIVE && send_index < frame_length)
                    begin
                        emit(hdecl_pkg::KIND_TX_BYTE, frame_bytes[send_index],
                             hdecl_pkg::ST_OK);
                        send_index = send_index + 1'b1;
                        // without echo checking the last byte out closes the frame
                        if (!echo_check && send_index >= frame_length)
                            end_send(hdecl_pkg::ST_OK);
                    end
                end
                hdecl_pkg::CMD_ABORT:
                begin
                    if (mode == hdecl_pkg::MODE_ACTIVE || send_pending)
                        end_send(hdecl_pkg::ST_ABORTED);
                    else
                        frame_length = '0;
                end
                default: ;
            endcase
            if (staged.size() != 0)
                staged[staged.size() - 1].last = 1'b1;
            foreach (staged[i])
                expected_results.push_back(staged[i]);
        endfunction

        function void compare_result(logic [2:0] kind, logic [15:0] data, logic last);
            hdecl_pkg::result_t exp_r;
            if (expected_results.size() == 0)
            begin
                $error("unexpected result: kind %0d, tdata %0h, tlast %0d", kind, data, last);
                error_count++;
                return;
            end
            exp_r = expected_results.pop_front();
            if (kind !== exp_r.kind)
            begin
                $error("kind: expected %0d, got %0d", exp_r.kind, kind);
                error_count++;
            end
            if (data[7:0] !== exp_r.data)
            begin
                $error("byte_out: expected %0h, got %0h", exp_r.data, data[7:0]);
                error_count++;
            end
            if (data[9:8] !== exp_r.status)
            begin
                $error("status: expected %0d, got %0d", exp_r.status, data[9:8]);
                error_count++;
            end
            if (data[15:10] !== 6'd0)
            begin
                $error("tdata_pad: expected 0, got %0h", data[15:10]);
                error_count++;
            end
            if (last !== exp_r.last)
            begin
                $error("last: expected %0d, got %0d", exp_r.last, last);
                error_count++;
            end
        endfunction

        function void report_leftovers();
            hdecl_pkg::result_t exp_r;
            while (expected_results.size() != 0)
            begin
                exp_r = expected_results.pop_front();
                $error("missing result: kind %0d, byte_out %0h, status %0d",
                       exp_r.kind, exp_r.data, exp_r.status);
                error_count++;
            end
        endfunction
    endclass

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [15:0] cfg_data  = '0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = '0;   // [7:0] byte_in
    logic [2:0]  s_tuser   = '0;   // [2:0] cmd
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [15:0] m_tdata;          // [7:0] byte_out, [9:8] status, [15:10] zero
    logic [2:0]  m_tuser;          // [2:0] kind
    logic        m_tlast;

    link_echo_board_t board;
    int unsigned    sent_items     = 0;
    int unsigned    send_idle_pct  = 16;
    int unsigned    recv_idle_pct  = 86;

    half_duplex_echo_collision_link i_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            board.compare_result(m_tuser, m_tdata, m_tlast);
    end

    // one event transfer; the prediction is updated at the accepting edge
    task automatic send_event(input logic [2:0] cmd, input logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= b;
        do
            @(posedge clk);
        while (!s_tready);
        board.apply_event(cmd, b);
        sent_items++;
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (board.expected_results.size() != 0);
        // an event with no result may still be in flight
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input hdecl_pkg::cfg_reg_t idx, input logic [15:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        board.set_register(idx, value);
        cfg_we    <= 1'b0;
        @(posedge clk);
    endtask

    task automatic program_link(input logic echo, input logic [15:0] gap_limit,
                                input logic [7:0] quiet, input logic [7:0] coll_base,
                                input logic [7:0] good_wait);
        write_reg(hdecl_pkg::REG_ECHO_CHECK, 16'(echo));
        write_reg(hdecl_pkg::REG_RX_GAP_TIMEOUT, gap_limit);
        write_reg(hdecl_pkg::REG_QUIET_GAP, 16'(quiet));
        write_reg(hdecl_pkg::REG_COLLISION_WAIT, 16'(coll_base));
        write_reg(hdecl_pkg::REG_SUCCESS_WAIT, 16'(good_wait));
    endtask

    task automatic send_noise();
        send_event(3'($urandom_range(7)), 8'($urandom));
    endtask

    task automatic run_idle_traffic(input int unsigned count);
        int unsigned pick;
        repeat (count)
        begin
            pick = $urandom_range(99);
            if (pick < 45)
                send_event(hdecl_pkg::CMD_TICK, 8'($urandom));
            else if (pick < 70)
                send_event(hdecl_pkg::CMD_RX, 8'($urandom));
            else if (pick < 75)
                send_event(hdecl_pkg::CMD_RX_ERR, 8'($urandom));
            else
                send_noise();
        end
    endtask

    // build or reuse a frame, wait for the start, then hand out and echo bytes
    task automatic run_session(input int unsigned max_len);
        int unsigned guard;
        int unsigned pick;
        int unsigned limit;
        if (board.frame_length == 0 || $urandom_range(3) == 0)
        begin
            if (board.frame_length != 0)
                send_event(hdecl_pkg::CMD_ABORT, 8'($urandom));
            repeat ($urandom_range(max_len, 1))
                send_event(hdecl_pkg::CMD_APPEND, 8'($urandom));
        end
        send_event(hdecl_pkg::CMD_REQUEST, 8'($urandom));
        guard = 0;
        while (board.send_pending && guard < 1000)
        begin
            if (guard < 40 && $urandom_range(15) == 0)
                send_event(hdecl_pkg::CMD_RX, 8'($urandom));
            else if ($urandom_range(79) == 0)
                send_event(hdecl_pkg::CMD_ABORT, 8'($urandom));
            else
                send_event(hdecl_pkg::CMD_TICK, 8'($urandom));
            guard++;
        end
        if (board.send_pending)
            send_event(hdecl_pkg::CMD_ABORT, 8'($urandom));
        guard = 0;
        limit = 8 * board.frame_length + 40;
        while (board.mode == hdecl_pkg::MODE_ACTIVE && guard < limit)
        begin
            pick = $urandom_range(99);
            if (pick < 40 && board.send_index < board.frame_length)
                send_event(hdecl_pkg::CMD_TX_RDY, 8'($urandom));
            else if (pick < 80)
            begin
                // mostly echo what went out, sometimes ahead of it
                if (board.verify_index < board.send_index || $urandom_range(9) == 0)
                    send_event(hdecl_pkg::CMD_RX, board.frame_bytes[board.verify_index]);
                else
                    send_event(hdecl_pkg::CMD_TICK, 8'($urandom));
            end
            else if (pick < 84)
                send_event(hdecl_pkg::CMD_RX, 8'($urandom));
            else if (pick < 86)
                send_event(hdecl_pkg::CMD_RX_ERR, 8'($urandom));
            else if (pick < 87)
                send_event(hdecl_pkg::CMD_ABORT, 8'($urandom));
            else if (pick < 95)
                send_event(hdecl_pkg::CMD_TICK, 8'($urandom));
            else
                send_noise();
            guard++;
        end
        if (board.mode == hdecl_pkg::MODE_ACTIVE)
            send_event(hdecl_pkg::CMD_ABORT, 8'($urandom));
    endtask

    // fill the store to the top, one append beyond, then collide on it
    task automatic send_full_frame();
        int unsigned guard;
        if (board.mode == hdecl_pkg::MODE_ACTIVE || board.send_pending)
            send_event(hdecl_pkg::CMD_ABORT, 8'h00);
        send_event(hdecl_pkg::CMD_ABORT, 8'h00);
        repeat (FRAME_DEPTH + 1)
            send_event(hdecl_pkg::CMD_APPEND, 8'($urandom));
        send_event(hdecl_pkg::CMD_REQUEST, 8'h00);
        guard = 0;
        while (board.send_pending && guard < 1000)
        begin
            send_event(hdecl_pkg::CMD_TICK, 8'h00);
            guard++;
        end
        repeat (3)
        begin
            send_event(hdecl_pkg::CMD_TX_RDY, 8'h00);
            if (board.mode == hdecl_pkg::MODE_ACTIVE)
                send_event(hdecl_pkg::CMD_RX, board.frame_bytes[board.verify_index]);
        end
        send_event(hdecl_pkg::CMD_RX_ERR, 8'h00);
        send_event(hdecl_pkg::CMD_ABORT, 8'h00);
    endtask

    initial
    begin
        int unsigned seg;
        int unsigned seg_end;
        int unsigned max_len;
        board = new();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part, reset register values
        send_event(hdecl_pkg::CMD_RX, 8'hff);
        send_event(CMD_UNUSED, 8'h00);
        send_event(hdecl_pkg::CMD_ABORT, 8'h00);       // idle, empty: nothing
        send_event(hdecl_pkg::CMD_REQUEST, 8'h00);     // empty frame: ignored
        send_event(hdecl_pkg::CMD_TX_RDY, 8'h00);      // not active: ignored
        send_event(hdecl_pkg::CMD_APPEND, 8'h00);
        send_event(hdecl_pkg::CMD_APPEND, 8'hff);
        send_event(hdecl_pkg::CMD_APPEND, 8'ha5);
        send_event(hdecl_pkg::CMD_REQUEST, 8'h00);     // line not quiet long enough yet
        send_event(hdecl_pkg::CMD_APPEND, 8'h11);      // pending: ignored
        send_event(hdecl_pkg::CMD_REQUEST, 8'h00);     // pending: ignored
        repeat (5) send_event(hdecl_pkg::CMD_TICK, 8'h00);
        send_event(hdecl_pkg::CMD_RX, 8'h00);          // echo before the byte is handed out
        send_event(hdecl_pkg::CMD_TX_RDY, 8'h00);
        send_event(hdecl_pkg::CMD_TX_RDY, 8'h00);
        send_event(hdecl_pkg::CMD_RX, 8'h7e);          // wrong echo: collision
        send_event(hdecl_pkg::CMD_REQUEST, 8'h00);     // retry waits out the backoff
        send_event(hdecl_pkg::CMD_ABORT, 8'h00);       // abort while pending
        send_event(hdecl_pkg::CMD_RX_ERR, 8'h00);

        for (seg = 0; seg < SEGMENTS; seg++)
        begin
            drain_results();
            case (seg)
                0: program_link(1'b1, 16'd1, 8'd0, 8'd0, 8'd0);
                1: program_link(1'b0, 16'hffff, 8'hff, 8'hff, 8'hff);
                3: program_link(1'b1, 16'($urandom_range(40, 1)), 8'($urandom_range(8)),
                                8'($urandom_range(24)), 8'($urandom_range(16)));
                default: program_link(1'($urandom_range(1)), 16'($urandom_range(40, 1)),
                                      8'($urandom_range(8)), 8'($urandom_range(24)),
                                      8'($urandom_range(16)));
            endcase
            if (seg < 2)
            begin
                send_idle_pct = 16;
                recv_idle_pct = 86;
            end
            else if (seg < 4)
            begin
                send_idle_pct = 86;
                recv_idle_pct = 16;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            seg_end = ITEM_TARGET * (seg + 1) / SEGMENTS;
            if (seg == 3)
                send_full_frame();
            while (sent_items < seg_end)
            begin
                max_len = ($urandom_range(7) == 0) ? 24 : 8;
                run_session(max_len);
                run_idle_traffic($urandom_range(6));
                if ($urandom_range(29) == 0)
                    drain_results();
            end
        end

        drain_results();
        board.report_leftovers();
        if (board.error_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+sv
sv/hdecl_pkg.sv
sv/half_duplex_echo_collision_link.sv
tb/half_duplex_echo_collision_link_tb.sv
